>>> sv/weighted_flow_split_forwarder_top_assert.svh
// Assertion macros for the weighted flow split forwarder.
// Used by the checker file; no other dependencies.
`ifndef WEIGHTED_FLOW_SPLIT_FORWARDER_TOP_ASSERT_SVH
`define WEIGHTED_FLOW_SPLIT_FORWARDER_TOP_ASSERT_SVH
`define WFS_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define WFS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> sv/wfsf_pkg.sv
// Package for the weighted flow split forwarder: types, codes, constants.
// No dependencies.
`default_nettype none
package wfsf_pkg;
  localparam int FlowEntriesDef = 64;
  localparam int ActionsDef     = 8;
  localparam int FracBitsDef    = 16;

  localparam logic [1:0] ModeAdd = 2'd0;
  localparam logic [1:0] ModeRec = 2'd1;
  localparam logic [1:0] ModeFwd = 2'd2;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StMiss      = 3'd1;
  localparam logic [2:0] StTableFull = 3'd2;
  localparam logic [2:0] StListFull  = 3'd3;
  localparam logic [2:0] StNoPort    = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN, S_ADD, S_FWD_RD, S_FWD_CMP, S_RC_FLOW, S_RC_CNT,
    S_RC_LOAD, S_RC_SORT, S_RC_DIV, S_RC_WAIT, S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  flow_protocol;
    logic [3:0]  port_index;
    logic [15:0] weight;
    logic [15:0] random_draw;
  } req_t;

  typedef struct packed {
    logic [3:0] chosen_port;
    logic [2:0] status;
  } rsp_t;
endpackage
`default_nettype wire

>>> sv/wfsf_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on wfsf_pkg.
`default_nettype none
interface wfsf_req_if import wfsf_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wfsf_rsp_if import wfsf_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/weighted_flow_split_forwarder_top.sv
// Top level of the weighted flow split forwarder.
// Depends on wfsf_pkg, wfsf_if, wfsf_front, wfsf_engine.
// One request is worked at a time and results leave in request order. The key
// search reads one flow entry at a time (registered read, then compare) and
// stops early when the key hits; a forward then walks the actions of the flow.
// Reconcile visits every flow slot, and for each valid flow reads its actions,
// sorts them with one compare-swap per cycle and runs a bit-serial divider of
// NW = 16+clog2(ACTIONS_PER_FLOW+1)+FRACTION_BITS bits per kept action.
// A two-entry input queue and a result register let each side stall on its own.
`default_nettype none
module weighted_flow_split_forwarder_top import wfsf_pkg::*; #(
  parameter int FLOW_ENTRIES     = FlowEntriesDef,
  parameter int ACTIONS_PER_FLOW = ActionsDef,
  parameter int FRACTION_BITS    = FracBitsDef
) (
  input wire clk_i,
  input wire rst_ni,
  wfsf_req_if.sink   in_if,
  wfsf_rsp_if.source out_if
);
  logic q_valid, q_pop;
  req_t q_data;

  wfsf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_data_i  (in_if.data),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_data_o   (q_data)
  );

  wfsf_engine #(
    .FlowEntries (FLOW_ENTRIES),
    .Actions     (ACTIONS_PER_FLOW),
    .FracBits    (FRACTION_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_data),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data)
  );
endmodule
`default_nettype wire

>>> sv/wfsf_front.sv
// Front end: takes requests into a short queue for the engine.
// Depends on wfsf_pkg.
`default_nettype none
module wfsf_front import wfsf_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      q_valid_o,
  input  wire       q_pop_i,
  output req_t      q_data_o
);
  req_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = q_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end
endmodule
`default_nettype wire

>>> sv/wfsf_divider.sv
// Restoring divider: quotient of num by den, one bit per cycle.
// Depends on nothing.
`default_nettype none
module wfsf_divider #(
  parameter int NumW = 48,
  parameter int DenW = 24
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  wire [NumW-1:0]  num_i,
  input  wire [DenW-1:0]  den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int CW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic [DenW:0]   sh;
  logic [DenW:0]   diff;

  assign sh     = {rem_q, quo_q[NumW-1]};
  assign diff   = sh - {1'b0, den_q};
  assign quo_o  = quo_q;
  assign done_o = busy_q && (cnt_q == CW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NumW);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != CW'(0)) begin
      if (!diff[DenW]) begin
        rem_q <= diff[DenW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= sh[DenW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/wfsf_engine.sv
// Back end: flow table search, add, reconcile and forward, one step a cycle unless waiting on the divider or output.
// Depends on wfsf_pkg and wfsf_divider.
`default_nettype none
module wfsf_engine import wfsf_pkg::*; #(
  parameter int FlowEntries = FlowEntriesDef,
  parameter int Actions     = ActionsDef,
  parameter int FracBits    = FracBitsDef
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       q_valid_i,
  output logic      q_pop_o,
  input  wire req_t q_data_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output rsp_t      out_data_o
);
  localparam int FW  = (FlowEntries > 1) ? $clog2(FlowEntries) : 1;
  localparam int AW  = (Actions > 1) ? $clog2(Actions) : 1;
  localparam int CW  = $clog2(Actions + 1);
  localparam int MW  = FW + AW;
  localparam int MD  = 1 << MW;
  localparam int TW  = FracBits + 1;
  localparam int SW  = 16 + CW;
  localparam int NW  = SW + FracBits;
  localparam int FCW = $clog2(FlowEntries + 1);
  localparam int KW  = 104;

  state_e state_q, state_d;

  // flow table
  logic [FlowEntries-1:0] valid_q;
  logic [CW-1:0]          cnt_m [FlowEntries];
  logic [KW-1:0]          key_m [FlowEntries];
  logic [CW-1:0]          cnt_rd_q;
  logic [KW-1:0]          key_rd_q;
  // action memories
  logic [3:0]             aport_m [MD];
  logic [15:0]            aw_m [MD];
  logic [TW-1:0]          ath_m [MD];
  logic [3:0]             rd_port_q;
  logic [15:0]            rd_w_q;
  logic [TW-1:0]          rd_th_q;

  req_t           req_q;
  logic [FW-1:0]  idx_q;
  logic [FCW-1:0] scan_q;
  logic           hit_q, free_q;
  logic [FW-1:0]  free_idx_q;
  logic [CW-1:0]  ai_q, n_q;
  rsp_t           rsp_q;
  rsp_t           out_q;
  logic           out_valid_q, out_valid_d;

  // reconcile buffers
  logic [3:0]    bp_q [Actions];
  logic [15:0]   bw_q [Actions];
  logic [CW-1:0] kept_q;
  logic [CW-1:0] si_q, sj_q;
  logic [SW-1:0] tot_q, cum_q;

  logic [FW-1:0] scan_idx;
  logic [KW-1:0] req_key;
  logic          key_eq;
  logic [MW-1:0] raddr, waddr;
  logic          rd_en, wr_en;
  logic [3:0]    wr_port;
  logic [15:0]   wr_w;
  logic [TW-1:0] wr_th;
  logic [TW-1:0] scaled;
  logic          div_start, div_done;
  logic [NW-1:0] div_quo;
  logic [TW-1:0] full;
  logic [SW-1:0] cum_nx;
  logic          sort_done;
  logic          fwd_hit;
  logic          key_we, cnt_we;
  logic [CW-1:0] cnt_wd;

  assign full      = {1'b1, {FracBits{1'b0}}};
  assign scan_idx  = scan_q[FW-1:0];
  assign req_key   = {req_q.src_ip, req_q.dst_ip, req_q.src_port, req_q.dst_port,
                      req_q.flow_protocol};
  assign key_eq    = valid_q[scan_idx] && (key_rd_q == req_key);
  assign cum_nx    = cum_q + SW'(bw_q[ai_q[AW-1:0]]);
  assign sort_done = (si_q >= kept_q);
  assign fwd_hit   = (scaled <= rd_th_q);

  generate
    if (FracBits >= 16) begin : g_up
      assign scaled = TW'({req_q.random_draw, {(FracBits - 16 + 1){1'b0}}} >> 1);
    end else begin : g_dn
      assign scaled = TW'(req_q.random_draw >> (16 - FracBits));
    end
  endgenerate

  wfsf_divider #(.NumW(NW), .DenW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({cum_nx, {FracBits{1'b0}}}),
    .den_i   (tot_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign raddr = {idx_q, ai_q[AW-1:0]};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (req_q.mode == ModeRec) begin
          state_d = S_RC_FLOW;
        end else if (req_q.mode != ModeAdd && req_q.mode != ModeFwd) begin
          state_d = S_OUT;
        end else if (key_eq || scan_q == FCW'(FlowEntries - 1)) begin
          state_d = (req_q.mode == ModeAdd) ? S_ADD : S_FWD_RD;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_ADD: begin
        state_d = S_OUT;
      end
      S_FWD_RD: begin
        state_d = (!hit_q || ai_q >= n_q) ? S_OUT : S_FWD_CMP;
      end
      S_FWD_CMP: begin
        state_d = fwd_hit ? S_OUT : S_FWD_RD;
      end
      S_RC_FLOW: begin
        if (scan_q == FCW'(FlowEntries)) begin
          state_d = S_OUT;
        end else if (valid_q[scan_idx]) begin
          state_d = S_RC_CNT;
        end
      end
      S_RC_CNT: begin
        state_d = S_RC_LOAD;
      end
      S_RC_LOAD: begin
        if (ai_q >= n_q) state_d = S_RC_SORT;
      end
      S_RC_SORT: begin
        if (sort_done) state_d = S_RC_DIV;
      end
      S_RC_DIV: begin
        state_d = (ai_q >= kept_q) ? S_RC_FLOW : S_RC_WAIT;
      end
      S_RC_WAIT: begin
        if (div_done) state_d = S_RC_DIV;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o   = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    waddr     = {idx_q, ai_q[AW-1:0]};
    wr_port   = req_q.port_index;
    wr_w      = req_q.weight;
    wr_th     = (req_q.weight != 16'd0) ? full : '0;
    div_start = 1'b0;
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    cnt_wd    = kept_q;
    case (state_q)
      S_IDLE: begin
        q_pop_o = q_valid_i;
      end
      S_ADD: begin
        wr_en  = (hit_q || free_q) && (n_q < CW'(Actions));
        waddr  = {idx_q, n_q[AW-1:0]};
        key_we = !hit_q && free_q;
        cnt_we = wr_en;
        cnt_wd = n_q + CW'(1);
      end
      S_FWD_RD: begin
        rd_en = hit_q && (ai_q < n_q);
      end
      S_RC_LOAD: begin
        rd_en = (ai_q < n_q);
      end
      S_RC_SORT: begin
        cnt_we = sort_done;
      end
      S_RC_DIV: begin
        div_start = (ai_q < kept_q);
      end
      S_RC_WAIT: begin
        if (div_done) begin
          wr_en   = 1'b1;
          wr_port = bp_q[ai_q[AW-1:0]];
          wr_w    = bw_q[ai_q[AW-1:0]];
          wr_th   = (ai_q == kept_q - CW'(1)) ? full : div_quo[TW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == S_OUT && state_d == S_IDLE) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      aport_m[waddr] <= wr_port;
      aw_m[waddr]    <= wr_w;
      ath_m[waddr]   <= wr_th;
    end
    if (rd_en) begin
      rd_port_q <= aport_m[raddr];
      rd_w_q    <= aw_m[raddr];
      rd_th_q   <= ath_m[raddr];
    end
    if (key_we) key_m[idx_q] <= req_key;
    if (cnt_we) cnt_m[idx_q] <= cnt_wd;
    key_rd_q <= key_m[scan_idx];
    cnt_rd_q <= cnt_m[scan_idx];
  end

  // output register
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (key_we) valid_q[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        req_q  <= q_data_i;
        scan_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        ai_q   <= '0;
        rsp_q  <= '{chosen_port: 4'd0, status: StOk};
      end
      S_SCAN: begin
        if (state_d == S_SCAN_RD) begin
          scan_q <= scan_q + FCW'(1);
          if (!valid_q[scan_idx] && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= scan_idx;
          end
        end else begin
          scan_q <= '0;
          if (key_eq) begin
            hit_q <= 1'b1;
            idx_q <= scan_idx;
            n_q   <= cnt_rd_q;
          end else if (free_q) begin
            idx_q <= free_idx_q;
            n_q   <= '0;
          end else if (!valid_q[scan_idx]) begin
            free_q <= 1'b1;
            idx_q  <= scan_idx;
            n_q    <= '0;
          end else begin
            n_q <= '0;
          end
        end
      end
      S_ADD: begin
        if (!hit_q && !free_q) rsp_q.status <= StTableFull;
        else if (n_q >= CW'(Actions)) rsp_q.status <= StListFull;
      end
      S_FWD_RD: begin
        if (!hit_q) rsp_q.status <= StMiss;
        else if (ai_q >= n_q) rsp_q.status <= StNoPort;
      end
      S_FWD_CMP: begin
        if (fwd_hit) rsp_q.chosen_port <= rd_port_q;
        ai_q <= ai_q + CW'(1);
      end
      S_RC_FLOW: begin
        idx_q  <= scan_idx;
        ai_q   <= '0;
        kept_q <= '0;
        tot_q  <= '0;
        scan_q <= scan_q + FCW'(1);
      end
      S_RC_CNT: begin
        n_q <= cnt_rd_q;
      end
      S_RC_LOAD: begin
        ai_q <= ai_q + CW'(1);
        if (ai_q != '0 && rd_w_q != 16'd0) begin
          bp_q[kept_q[AW-1:0]] <= rd_port_q;
          bw_q[kept_q[AW-1:0]] <= rd_w_q;
          kept_q <= kept_q + CW'(1);
          tot_q  <= tot_q + SW'(rd_w_q);
        end
        si_q <= CW'(1);
        sj_q <= CW'(1);
      end
      S_RC_SORT: begin
        // insertion sort, one compare-swap per cycle
        if (si_q < kept_q) begin
          if (sj_q != '0 && bw_q[sj_q[AW-1:0] - AW'(1)] < bw_q[sj_q[AW-1:0]]) begin
            bw_q[sj_q[AW-1:0]] <= bw_q[sj_q[AW-1:0] - AW'(1)];
            bp_q[sj_q[AW-1:0]] <= bp_q[sj_q[AW-1:0] - AW'(1)];
            bw_q[sj_q[AW-1:0] - AW'(1)] <= bw_q[sj_q[AW-1:0]];
            bp_q[sj_q[AW-1:0] - AW'(1)] <= bp_q[sj_q[AW-1:0]];
            sj_q <= sj_q - CW'(1);
          end else begin
            si_q <= si_q + CW'(1);
            sj_q <= si_q + CW'(1);
          end
        end
        ai_q  <= '0;
        cum_q <= '0;
      end
      S_RC_DIV: begin
        if (ai_q < kept_q) cum_q <= cum_nx;
      end
      S_RC_WAIT: begin
        if (div_done) ai_q <= ai_q + CW'(1);
      end
      S_OUT: begin
        if (state_d == S_IDLE) out_q <= rsp_q;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> sv/wfsf_checker.sv
// Port-level checker for the forwarder, bound to the top level.
// Depends on wfsf_pkg and the assertion macro header.
`default_nettype none
`include "weighted_flow_split_forwarder_top_assert.svh"
module wfsf_port_assert import wfsf_pkg::*; (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid,
  input wire       out_ready,
  input wire [3:0] out_port,
  input wire [2:0] out_status
);
  `WFS_ASSERT_IMPL(a_status_rng, clk_i, rst_ni, out_valid, out_status <= StNoPort)
  `WFS_ASSERT_IMPL(a_port_zero, clk_i, rst_ni, out_valid && out_status != StOk, out_port == 4'd0)
  `WFS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
endmodule

bind weighted_flow_split_forwarder_top wfsf_port_assert u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_port   (out_if.data.chosen_port),
  .out_status (out_if.data.status)
);
`default_nettype wire
